>>> src/pattern_depuncturer_unit_macros.svh
// Assertion macros used by the checker of the depuncturer
`ifndef PATTERN_DEPUNCTURER_UNIT_MACROS_SVH
`define PATTERN_DEPUNCTURER_UNIT_MACROS_SVH

// Clocked property, ignored while reset is asserted
`define PDP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property, checked also during reset
`define PDP_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/pdp_pkg.sv
// Types and constants of the pattern depuncturer
package pdp_pkg;

    localparam int PERIOD_W  = 7;
    localparam int PATTERN_W = 64;
    localparam int SYM_W     = 8;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILL    = 2'd2;

    localparam logic [PERIOD_W-1:0]  PERIOD_RST  = 7'd8;
    localparam logic [PATTERN_W-1:0] PATTERN_RST = 64'hFF;
    localparam logic [SYM_W-1:0]     FILL_RST    = 8'd0;

    // Controller to datapath
    typedef struct packed {
        logic load_byte;  // capture the incoming item
        logic emit;       // produce one result this cycle
    } pdp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;   // output register can take a result
        logic kept;       // current position keeps the byte (ends the run)
    } pdp_stat_t;

endpackage

>>> src/pdp_datapath.sv
// Datapath: configuration registers, pattern walk and output register
module pdp_datapath import pdp_pkg::*; #(
    parameter int MAX_PERIOD = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PATTERN_W-1:0] cfg_data,
    input  logic [SYM_W-1:0]     in_byte,
    input  logic                 m_tready,
    input  pdp_cmd_t             cmd,
    output pdp_stat_t            stat,
    output logic                 m_tvalid,
    output logic [SYM_W-1:0]     m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast
);

    localparam int PW = $clog2(MAX_PERIOD);

    logic [PERIOD_W-1:0]   period_reg;
    logic [MAX_PERIOD-1:0] pattern_reg;
    logic [SYM_W-1:0]      fill_reg;
    logic [PW-1:0]         pos_reg, pos_next;
    logic [SYM_W-1:0]      byte_reg;
    logic                  out_valid_reg;
    logic [SYM_W-1:0]      out_sym_reg;
    logic                  out_fill_reg;
    logic                  out_last_reg;

    logic [PERIOD_W-1:0]   eff_p;
    logic [MAX_PERIOD-1:0] mask;
    logic [MAX_PERIOD-1:0] pat;
    logic                  pat_zero;
    logic [PERIOD_W-1:0]   pos_use;
    logic [PERIOD_W-1:0]   bit_idx;
    logic [PERIOD_W-1:0]   pos_inc;
    logic                  bit_kept;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg  <= PERIOD_RST;
            pattern_reg <= PATTERN_RST[MAX_PERIOD-1:0];
            fill_reg    <= FILL_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_PERIOD:  period_reg  <= cfg_data[PERIOD_W-1:0];
                REG_PATTERN: pattern_reg <= cfg_data[MAX_PERIOD-1:0];
                REG_FILL:    fill_reg    <= cfg_data[SYM_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective period clamped to 1..MAX_PERIOD, pattern trimmed to it
    always_comb begin
        if (period_reg == '0) begin
            eff_p = PERIOD_W'(1);
        end else if (period_reg > PERIOD_W'(MAX_PERIOD)) begin
            eff_p = PERIOD_W'(MAX_PERIOD);
        end else begin
            eff_p = period_reg;
        end
        for (int i = 0; i < MAX_PERIOD; i++) begin
            mask[i] = (PERIOD_W'(i) < eff_p);
        end
        pat      = pattern_reg & mask;
        pat_zero = (pat == '0);
    end

    // Current position, restarted if the period shrank under it
    always_comb begin
        pos_use  = (PERIOD_W'(pos_reg) >= eff_p) ? '0 : PERIOD_W'(pos_reg);
        bit_idx  = eff_p - PERIOD_W'(1) - pos_use;
        bit_kept = pat[bit_idx[PW-1:0]];
        pos_inc  = pos_use + PERIOD_W'(1);
        if (pos_inc >= eff_p) begin
            pos_next = '0;
        end else begin
            pos_next = pos_inc[PW-1:0];
        end
    end

    assign stat.kept     = pat_zero || bit_kept;
    assign stat.out_free = !out_valid_reg || m_tready;

    // Position walks only on emitted results of a nonzero pattern
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (cmd.emit && !pat_zero) begin
            pos_reg <= pos_next;
        end
    end

    // Captured input item
    always_ff @(posedge aclk) begin
        if (cmd.load_byte) begin
            byte_reg <= in_byte;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_sym_reg  <= stat.kept ? byte_reg : fill_reg;
            out_fill_reg <= !stat.kept;
            out_last_reg <= stat.kept;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sym_reg;
    assign m_tuser  = out_fill_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> src/pdp_ctrl.sv
// Controller: takes input items and sequences the results of each run
module pdp_ctrl import pdp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  pdp_stat_t stat,
    output pdp_cmd_t  cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg;
    logic   run_done;
    logic   accept;

    // A run ends on the result that carries the byte; the next item
    // may be taken in that same cycle
    assign cmd.emit      = (state_reg == ST_RUN) && stat.out_free;
    assign run_done      = cmd.emit && stat.kept;
    assign s_tready      = (state_reg == ST_IDLE) || run_done;
    assign accept        = s_tvalid && s_tready;
    assign cmd.load_byte = accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            case (state_reg)
                ST_IDLE: if (accept) state_reg <= ST_RUN;
                ST_RUN:  if (run_done && !accept) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

>>> src/pattern_depuncturer_unit.sv
// Pattern depuncturer: fills punctured holes back into a symbol stream
//
// Input channel s_*: one received byte per item. Output channel m_*: one
// symbol per item, tuser high on inserted fill symbols, tlast high on the
// item that carries the received byte (the end of its run).
// Configuration channel cfg_*: index 0 period, 1 keep pattern (low period
// bits, MSB first), 2 fill symbol; cfg_ready is always high and writes are
// expected only while the block is idle.
// Each input item gives a run of h+1 output items, h being the holes before
// the next kept position; the run is produced one item per cycle, while the
// output does not stall, from a single output register, and the next input
// item is accepted in the cycle the current run's last item is produced.
// An accepted byte is captured before its run writes the output register.
// An all-zero pattern passes each byte through as a run of one.
// Reset returns the registers to period 8, pattern 0xFF, fill 0, and the
// walk to the start of the period. When m_tready is low the output register
// holds its item and the run stalls, and so does the input channel mid-run.
module pattern_depuncturer_unit import pdp_pkg::*; #(
    parameter int MAX_PERIOD = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [SYM_W-1:0]     s_tdata,   // [7:0] sym_in
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [SYM_W-1:0]     m_tdata,   // [7:0] sym_out
    output logic                 m_tuser,   // [0] is_fill
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PATTERN_W-1:0] cfg_data
);

    pdp_cmd_t  cmd;
    pdp_stat_t stat;

    assign cfg_ready = 1'b1;

    pdp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pdp_datapath #(
        .MAX_PERIOD (MAX_PERIOD)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_byte   (s_tdata),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

>>> src/pdp_checker.sv
// Port-level checks of the depuncturer, bound to the top level
`include "pattern_depuncturer_unit_macros.svh"

module pdp_checker import pdp_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [SYM_W-1:0]     m_tdata,
    input logic                 m_tuser,
    input logic                 m_tlast
);

    // Output register empties on reset
    `PDP_ASSERT_RST(a_rst_empty, aclk, !aresetn |=> !m_tvalid, "output valid after reset")

    // A stalled output item stays and holds its payload
    `PDP_ASSERT(a_out_hold, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast),
        "stalled output item changed")

    // A fill symbol never ends a run
    `PDP_ASSERT(a_fill_not_last, aclk, aresetn, m_tvalid |-> !(m_tuser && m_tlast), "fill item flagged last")

    // While the output stalls in mid-run no new input item is taken
    `PDP_ASSERT(a_no_take_on_stall, aclk, aresetn,
        m_tvalid && !m_tready && !m_tlast && $past(s_tvalid && s_tready) == 1'b0
            && $past(m_tvalid) && !$past(m_tlast) |-> !s_tready,
        "input taken during stalled run")

endmodule

bind pattern_depuncturer_unit pdp_checker u_pdp_checker (.*);
